@@ hw/rtl/lap3_pkg.sv @@
// Shared types and constants for the 3x3 four-neighbour Laplacian filter.
// No dependencies; used by every module of the block.
package lap3_pkg;

    localparam int LAP3_MAX_WIDTH = 2048;   // default line store depth

    localparam int PIX_W      = 16;         // unsigned Q0.16 gray level
    localparam int LAP_W      = 19;         // signed result
    localparam int SUM_W      = LAP_W + 1;  // headroom for the five-term sum
    localparam int CFG_W_BITS = 12;         // frame_width register
    localparam int CFG_H_BITS = 16;         // frame_height register
    localparam int CFG_DATA_W = 16;         // widest register
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_W_BITS-1:0] RESET_FRAME_WIDTH  = 12'd2048;
    localparam logic [CFG_H_BITS-1:0] RESET_FRAME_HEIGHT = 16'd2048;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // prefetched line store taps for the incoming column
    typedef struct packed {
        logic [PIX_W-1:0] ctr;  // centre row, this column
        logic [PIX_W-1:0] up;   // upper row, this column
        logic [PIX_W-1:0] rt;   // centre row, next column
    } t_taps;

    typedef struct packed {
        logic signed [LAP_W-1:0] laplacian;
        logic                    frame_end;
    } t_result;

endpackage

@@ hw/rtl/laplacian_3x3_filter_core.sv @@
// Top level of the streaming 3x3 four-neighbour Laplacian filter.
// Depends on lap3_pkg, lap3_line_buf and lap3_out_buf.
//
// Takes one unsigned Q0.16 pixel per clock in raster order while o_ready is
// high and returns 4*centre - up - down - left - right as a 19-bit signed
// value, with pixels outside the frame taken as zero. The result for a pixel
// leaves when the pixel below it enters, so the first row of a frame gives no
// result and the source appends one padding row (values ignored) to flush the
// last row; frame_end marks the frame's last result. Throughput is one item
// per clock while no register is written and the consumer takes every result:
// the line stores are read ahead of the incoming column, and that prefetch
// holds o_ready low until its first fetch after reset and in the cycle after
// every register write. Results are registered in a two-entry buffer (output
// and skid); an item accepted while the consumer stalls waits in the skid.
module laplacian_3x3_filter_core #(
    parameter int MAX_WIDTH = lap3_pkg::LAP3_MAX_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lap3_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [lap3_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [lap3_pkg::PIX_W-1:0]          i_pixel,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [lap3_pkg::LAP_W-1:0]   o_laplacian,
    output logic                                o_frame_end
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = (AW + 1 > lap3_pkg::CFG_W_BITS) ? AW + 1 : lap3_pkg::CFG_W_BITS;
    localparam int HW = lap3_pkg::CFG_H_BITS;
    localparam int PW = lap3_pkg::PIX_W;
    localparam int SW = lap3_pkg::SUM_W;
    localparam logic [CW-1:0] MAX_W_C = CW'(MAX_WIDTH);

    logic [lap3_pkg::CFG_W_BITS-1:0] r_cfg_w;
    logic [HW-1:0]                   r_cfg_h;
    logic [lap3_pkg::CFG_W_BITS-1:0] n_cfg_w;
    logic [HW-1:0]                   n_cfg_h;
    logic [AW-1:0]                   r_col;
    logic [HW-1:0]                   r_row;
    logic [PW-1:0]                   r_left;
    logic                            r_fetch_ok;

    logic [CW-1:0]   cfg_w_ext;
    logic [CW-1:0]   eff_w;
    logic [HW-1:0]   eff_h;
    logic            col_wrap;
    logic [AW-1:0]   cur_col;
    logic [HW:0]     row_tmp;
    logic [HW-1:0]   cur_row;
    logic [AW:0]     col_inc;
    logic            last_col;
    logic [AW-1:0]   nxt_col;
    logic [HW-1:0]   nxt_row;
    logic            acc;
    logic            produce;
    logic            room;
    logic [AW-1:0]   rd_col;

    lap3_pkg::t_taps   taps;
    lap3_pkg::t_result res;
    lap3_pkg::t_result out_res;

    logic [PW-1:0]        up_v;
    logic [PW-1:0]        dn_v;
    logic [PW-1:0]        lf_v;
    logic [PW-1:0]        rt_v;
    logic signed [SW-1:0] lap_sum;

    // ---------------- configuration ----------------
    always_comb begin
        n_cfg_w = r_cfg_w;
        n_cfg_h = r_cfg_h;
        if (i_cfg_we) begin
            unique case (lap3_pkg::t_cfg_reg'(i_cfg_addr))
                lap3_pkg::REG_FRAME_WIDTH:  n_cfg_w = i_cfg_data[lap3_pkg::CFG_W_BITS-1:0];
                lap3_pkg::REG_FRAME_HEIGHT: n_cfg_h = i_cfg_data[HW-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_w_ext = CW'(r_cfg_w);
    assign eff_w = (cfg_w_ext == '0) ? CW'(1) :
                   (cfg_w_ext > MAX_W_C) ? MAX_W_C : cfg_w_ext;
    assign eff_h = (r_cfg_h == '0) ? HW'(1) : r_cfg_h;

    // ---------------- position of the incoming item ----------------
    // counters left out of range by a register write close the row / frame
    assign col_wrap = (CW'(r_col) >= eff_w);
    assign cur_col  = col_wrap ? '0 : r_col;
    assign row_tmp  = col_wrap ? ({1'b0, r_row} + (HW+1)'(1)) : {1'b0, r_row};
    assign cur_row  = (row_tmp > {1'b0, eff_h}) ? '0 : row_tmp[HW-1:0];

    assign col_inc  = {1'b0, cur_col} + (AW+1)'(1);
    assign last_col = (CW'(col_inc) >= eff_w);
    assign nxt_col  = last_col ? '0 : col_inc[AW-1:0];
    assign nxt_row  = !last_col ? cur_row :
                      (cur_row >= eff_h) ? '0 : cur_row + HW'(1);

    assign o_ready = r_fetch_ok && room;
    assign acc     = i_valid && o_ready;
    assign produce = acc && (cur_row != '0);

    // prefetch the column that the next item will use
    assign rd_col = acc ? nxt_col : cur_col;

    lap3_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk    (i_clk),
        .i_rd_col (rd_col),
        .i_wr_en  (acc),
        .i_wr_col (cur_col),
        .i_wr_pix (i_pixel),
        .i_wr_ctr (taps.ctr),
        .o_taps   (taps)
    );

    // ---------------- kernel ----------------
    assign up_v = (cur_row >= HW'(2)) ? taps.up : '0;
    assign dn_v = (cur_row < eff_h)   ? i_pixel : '0;
    assign lf_v = (cur_col != '0)     ? r_left  : '0;
    assign rt_v = !last_col           ? taps.rt : '0;

    assign lap_sum = $signed({2'b00, taps.ctr, 2'b00})
                   - $signed({4'b0000, up_v})
                   - $signed({4'b0000, dn_v})
                   - $signed({4'b0000, lf_v})
                   - $signed({4'b0000, rt_v});

    assign res.laplacian = lap_sum[lap3_pkg::LAP_W-1:0];
    assign res.frame_end = (cur_row == eff_h) && (CW'(col_inc) == eff_w);

    // ---------------- state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= lap3_pkg::RESET_FRAME_WIDTH;
            r_cfg_h    <= lap3_pkg::RESET_FRAME_HEIGHT;
            r_col      <= '0;
            r_row      <= '0;
            r_left     <= '0;
            r_fetch_ok <= 1'b0;
        end else begin
            r_cfg_w    <= n_cfg_w;
            r_cfg_h    <= n_cfg_h;
            r_fetch_ok <= !i_cfg_we;
            if (acc) begin
                r_col  <= nxt_col;
                r_row  <= nxt_row;
                r_left <= taps.ctr;
            end
        end
    end

    lap3_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (produce),
        .i_res   (res),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    assign o_laplacian = out_res.laplacian;
    assign o_frame_end = out_res.frame_end;

    // ---------------- assertions ----------------
    a_cfg_refetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_ready)
        else $error("item accepted before line store prefetch caught up with config");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_cfg_we) |=> (CW'(r_col) < eff_w))
        else $error("column counter left the row");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (produce && res.frame_end && !i_cfg_we) |=> (r_col == '0 && r_row == '0))
        else $error("frame did not restart after its last result");

    a_no_result_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && cur_row == '0) |-> !produce)
        else $error("result produced for the first input row");

endmodule

@@ hw/rtl/lap3_line_buf.sv @@
// Two line stores (centre and upper rows) with registered, prefetched reads.
// Depends on lap3_pkg.
module lap3_line_buf #(
    parameter int MAX_WIDTH = lap3_pkg::LAP3_MAX_WIDTH
) (
    input  logic                           i_clk,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_rd_col,
    input  logic                           i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_wr_col,
    input  logic [lap3_pkg::PIX_W-1:0]     i_wr_pix,
    input  logic [lap3_pkg::PIX_W-1:0]     i_wr_ctr,
    output lap3_pkg::t_taps                o_taps
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [lap3_pkg::PIX_W-1:0] r_centre_mem [MAX_WIDTH];
    logic [lap3_pkg::PIX_W-1:0] r_upper_mem  [MAX_WIDTH];
    logic [lap3_pkg::PIX_W-1:0] r_ctr_q;
    logic [lap3_pkg::PIX_W-1:0] r_up_q;
    logic [lap3_pkg::PIX_W-1:0] r_rt_q;
    logic [AW-1:0]              rd_nxt;

    // wraps past the last entry only when the right tap is masked anyway
    assign rd_nxt = i_rd_col + AW'(1);

    // same-cycle write to a read address is forwarded (write-first)
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_centre_mem[i_wr_col] <= i_wr_pix;
            r_upper_mem[i_wr_col]  <= i_wr_ctr;
        end
        r_ctr_q <= (i_wr_en && i_wr_col == i_rd_col) ? i_wr_pix : r_centre_mem[i_rd_col];
        r_rt_q  <= (i_wr_en && i_wr_col == rd_nxt)   ? i_wr_pix : r_centre_mem[rd_nxt];
        r_up_q  <= (i_wr_en && i_wr_col == i_rd_col) ? i_wr_ctr : r_upper_mem[i_rd_col];
    end

    assign o_taps.ctr = r_ctr_q;
    assign o_taps.up  = r_up_q;
    assign o_taps.rt  = r_rt_q;

endmodule

@@ hw/rtl/lap3_out_buf.sv @@
// Result register with a skid stage; ready toward the core is registered.
// Depends on lap3_pkg.
module lap3_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lap3_pkg::t_result i_res,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output lap3_pkg::t_result o_res
);

    logic              r_out_v;
    logic              r_skid_v;
    lap3_pkg::t_result r_out;
    lap3_pkg::t_result r_skid;
    logic              n_out_v;
    logic              n_skid_v;
    logic              load_out;

    assign load_out = !r_out_v || i_ready;

    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        if (load_out) begin
            n_out_v  = r_skid_v || i_push;
            n_skid_v = 1'b0;
        end else if (i_push) begin
            n_skid_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    // push never arrives while the skid is full (o_room low)
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_skid_v ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

    assign o_room  = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_res   = r_out;

endmodule
